// ===== hdl/gbrsc_pkg.sv =====
package gbrsc_pkg;

    // Stick axes that are actually conditioned (1..4); the rest read as zero
    localparam int NumAxes = 4;

    localparam int BtnW  = 16;
    localparam int AxisW = 8;
    localparam int CfgW  = 64;
    localparam int MapRegs = 4;

    // Generalize remap masks
    localparam logic [BtnW-1:0] SelectMask    = 16'd15;
    localparam logic [BtnW-1:0] StartMask     = 16'd368;
    localparam logic [BtnW-1:0] SelectClear   = 16'b1111111111110000;
    localparam logic [BtnW-1:0] StartClear    = 16'b1111111010001111;
    localparam logic [BtnW-1:0] ReservedClear = 16'b1111111111111001;
    localparam int SelectBit = 0;
    localparam int StartBit  = 3;

    // Stick conditioning
    localparam logic [AxisW-1:0] AxMin    = 8'd4;
    localparam logic [AxisW-1:0] AxMax    = 8'd120;
    localparam logic [AxisW-1:0] AxCenter = 8'd62;
    localparam logic signed [9:0] AxDead  = 10'sd3;
    localparam logic signed [9:0] AxClip  = 10'sd127;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_GENERALIZE = 3'd0,
        CFG_MAP_0_3    = 3'd1,
        CFG_MAP_4_7    = 3'd2,
        CFG_MAP_8_11   = 3'd3,
        CFG_MAP_12_15  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             good;
        logic [AxisW-1:0] val;
    } t_axis_res;

    // Range check, center, deadzone, scale by 4 and clip one raw axis value
    function automatic t_axis_res cond_axis(input logic [AxisW-1:0] raw);
        t_axis_res        res;
        logic signed [9:0] d;
        logic signed [9:0] r;
        res.good = (raw >= AxMin) && (raw <= AxMax);
        d = $signed({2'b00, raw}) - $signed({2'b00, AxCenter});
        if ((d > -AxDead) && (d < AxDead)) begin
            r = 10'sd0;
        end else begin
            r = d <<< 2;
            if (r > AxClip) begin
                r = AxClip;
            end
            if (r < -AxClip) begin
                r = -AxClip;
            end
        end
        res.val = r[AxisW-1:0];
        return res;
    endfunction

endpackage

// ===== hdl/gamepad_button_remap_and_stick_condition_unit.sv =====
// A request accepted into the input register moves on to the result register and is
// taken from there. Throughput: one request per cycle while o_in_stall is low; the
// input and result registers advance together.
// Reset: i_rst_n synchronous, active low; generalize mode on, remap masks,
// last good axes and held result all zero, both stages empty.
module gamepad_button_remap_and_stick_condition_unit
    import gbrsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [CfgW-1:0]        i_cfg_data,
    // poll requests
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_received,
    input  logic [BtnW-1:0]        i_raw_buttons,
    input  logic [AxisW-1:0]       i_raw_axis_0,
    input  logic [AxisW-1:0]       i_raw_axis_1,
    input  logic [AxisW-1:0]       i_raw_axis_2,
    input  logic [AxisW-1:0]       i_raw_axis_3,
    // results
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_fresh,
    output logic [BtnW-1:0]        o_common_buttons,
    output logic signed [AxisW-1:0] o_stick_0,
    output logic signed [AxisW-1:0] o_stick_1,
    output logic signed [AxisW-1:0] o_stick_2,
    output logic signed [AxisW-1:0] o_stick_3
);

    // configuration registers
    logic                  r_gen;
    logic [CfgW-1:0]       r_map [MapRegs];

    // input stage
    logic                  r_s1_valid;
    logic                  r_s1_received;
    logic [BtnW-1:0]       r_s1_buttons;
    logic [AxisW-1:0]      r_s1_axis [4];

    // result stage and held state
    logic                  r_out_valid;
    logic                  r_fresh;
    logic [BtnW-1:0]       r_held_buttons;
    logic [AxisW-1:0]      r_held_sticks [4];
    logic [AxisW-1:0]      r_last_good [4];

    logic                  out_stall;
    logic                  s2_load;
    logic                  in_acc;
    logic [BtnW-1:0]       n_common;
    logic [BtnW-1:0]       btn_left;
    logic [BtnW-1:0]       remap;
    t_axis_res             axis_res [4];
    logic [AxisW-1:0]      n_stick [4];

    // handshake: stage 1 moves on when the result register is free or drains
    assign out_stall  = r_out_valid && i_out_stall;
    assign s2_load    = r_s1_valid && !out_stall;
    assign o_in_stall = r_s1_valid && out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 1'b1;
            for (int k = 0; k < MapRegs; k++) begin
                r_map[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GENERALIZE: r_gen    <= i_cfg_data[0];
                CFG_MAP_0_3:    r_map[0] <= i_cfg_data;
                CFG_MAP_4_7:    r_map[1] <= i_cfg_data;
                CFG_MAP_8_11:   r_map[2] <= i_cfg_data;
                CFG_MAP_12_15:  r_map[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_received <= i_received;
            r_s1_buttons  <= i_raw_buttons;
            r_s1_axis[0]  <= i_raw_axis_0;
            r_s1_axis[1]  <= i_raw_axis_1;
            r_s1_axis[2]  <= i_raw_axis_2;
            r_s1_axis[3]  <= i_raw_axis_3;
        end
    end

    // button remap: select and start combos first, then the mask table
    always_comb begin
        btn_left = r_s1_buttons;
        remap    = '0;
        if ((btn_left & SelectMask) == SelectMask) begin
            remap[SelectBit] = 1'b1;
            btn_left         = btn_left & SelectClear;
        end
        if ((btn_left & StartMask) == StartMask) begin
            remap[StartBit] = 1'b1;
            btn_left        = btn_left & StartClear;
        end
        for (int b = 0; b < BtnW; b++) begin
            if ((r_map[b / 4][(b % 4) * BtnW +: BtnW] & btn_left) != '0) begin
                remap[b] = 1'b1;
            end
        end
        remap    = remap & ReservedClear;
        n_common = r_gen ? remap : r_s1_buttons;
    end

    // per-axis conditioning; a bad value falls back to the last good one, raw mode gives zero
    always_comb begin
        for (int a = 0; a < 4; a++) begin
            axis_res[a] = cond_axis(r_s1_axis[a]);
            if (!r_gen || (a >= NumAxes)) begin
                n_stick[a] = '0;
            end else if (axis_res[a].good) begin
                n_stick[a] = axis_res[a].val;
            end else begin
                n_stick[a] = r_last_good[a];
            end
        end
    end

    // result register; a failed poll keeps the held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_fresh        <= 1'b0;
            r_held_buttons <= '0;
            for (int a = 0; a < 4; a++) begin
                r_held_sticks[a] <= '0;
                r_last_good[a]   <= '0;
            end
        end else begin
            if (s2_load) begin
                r_out_valid <= 1'b1;
                r_fresh     <= r_s1_received;
                if (r_s1_received) begin
                    r_held_buttons <= n_common;
                    for (int a = 0; a < 4; a++) begin
                        r_held_sticks[a] <= n_stick[a];
                        if (r_gen && (a < NumAxes) && axis_res[a].good) begin
                            r_last_good[a] <= axis_res[a].val;
                        end
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fresh          = r_fresh;
    assign o_common_buttons = r_held_buttons;
    assign o_stick_0        = r_held_sticks[0];
    assign o_stick_1        = r_held_sticks[1];
    assign o_stick_2        = r_held_sticks[2];
    assign o_stick_3        = r_held_sticks[3];

`ifndef SYNTHESIS
    // stall toward the source only with a request parked in stage 1
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stall without a parked request");

    // a failed poll repeats the held buttons
    a_failed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && !r_s1_received) |=> ($stable(o_common_buttons) && !o_fresh))
        else $error("failed poll changed held result");

    // raw mode gives zero sticks
    a_raw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && r_s1_received && !r_gen) |=>
        (o_stick_0 == '0 && o_stick_1 == '0 && o_stick_2 == '0 && o_stick_3 == '0))
        else $error("raw mode stick not zero");

    // generalized buttons never carry bits 1 and 2
    a_reserved_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && r_s1_received && r_gen) |=>
        (!o_common_buttons[1] && !o_common_buttons[2]))
        else $error("reserved button bits set");

    // clipping never yields the most negative code
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stick_0 != 8'h80) && (o_stick_1 != 8'h80) &&
        (o_stick_2 != 8'h80) && (o_stick_3 != 8'h80))
        else $error("stick out of clip range");
`endif

endmodule

// ===== bench/gamepad_button_remap_and_stick_condition_unit_test.sv =====
module gamepad_button_remap_and_stick_condition_unit_test;
    import gbrsc_pkg::*;

    // One result as the block presents it; sticks[0] is axis 0
    typedef struct packed {
        logic                       fresh;
        logic [BtnW-1:0]            buttons;
        logic [3:0][AxisW-1:0]      sticks;
    } poll_result_t;

    // Predicts each poll result and checks the block's results in order
    class poll_scoreboard;
        localparam int StickDead = 3;
        localparam int StickGain = 4;
        localparam int StickClip = 127;

        int                 errors = 0;
        logic               gen_mode = 1'b1;
        logic [CfgW-1:0]    map_word [MapRegs] = '{default: '0};
        logic [AxisW-1:0]   last_good [4] = '{default: '0};
        poll_result_t       held = '0;
        poll_result_t       due_results [$];

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        function void set_register(t_cfg_idx idx, logic [CfgW-1:0] value);
            case (idx)
                CFG_GENERALIZE: gen_mode = value[0];
                CFG_MAP_0_3:    map_word[0] = value;
                CFG_MAP_4_7:    map_word[1] = value;
                CFG_MAP_8_11:   map_word[2] = value;
                CFG_MAP_12_15:  map_word[3] = value;
                default: ;
            endcase
        endfunction

        // Select and start combos first, then the mask table on what is left
        function logic [BtnW-1:0] remap_buttons(logic [BtnW-1:0] raw);
            logic [BtnW-1:0] left;
            logic [BtnW-1:0] word;
            left = raw;
            word = '0;
            if ((left & SelectMask) == SelectMask) begin
                word[SelectBit] = 1'b1;
                left &= ~SelectMask;
            end
            if ((left & StartMask) == StartMask) begin
                word[StartBit] = 1'b1;
                left &= ~StartMask;
            end
            for (int e = 0; e < 16; e++) begin
                if ((map_word[e / 4][(e % 4) * 16 +: 16] & left) != '0) begin
                    word[e] = 1'b1;
                end
            end
            // bits 1 and 2 are reserved and always read zero
            word[2:1] = 2'b00;
            return word;
        endfunction

        // Out-of-range raw value keeps the last good value of that axis
        function logic [AxisW-1:0] condition_stick(int ax, logic [AxisW-1:0] raw);
            int offs;
            int scaled;
            if (raw < AxMin || raw > AxMax) begin
                return last_good[ax];
            end
            offs = int'(raw) - int'(AxCenter);
            if (offs > -StickDead && offs < StickDead) begin
                scaled = 0;
            end else begin
                scaled = offs * StickGain;
                if (scaled > StickClip) scaled = StickClip;
                if (scaled < -StickClip) scaled = -StickClip;
            end
            last_good[ax] = scaled[AxisW-1:0];
            return last_good[ax];
        endfunction

        // A failed poll repeats the held result with fresh low
        function void note_poll(logic received, logic [BtnW-1:0] buttons,
                                logic [3:0][AxisW-1:0] axes);
            if (received) begin
                held.buttons = gen_mode ? remap_buttons(buttons) : buttons;
                held.sticks = '0;
                if (gen_mode) begin
                    for (int ax = 0; ax < 4; ax++) begin
                        if (ax < NumAxes) held.sticks[ax] = condition_stick(ax, axes[ax]);
                    end
                end
            end
            held.fresh = received;
            due_results.push_back(held);
        endfunction

        task check_result(poll_result_t got);
            poll_result_t want;
            if (due_results.size() == 0) begin
                report("result with no poll outstanding");
                return;
            end
            want = due_results.pop_front();
            if (got.fresh !== want.fresh)
                report($sformatf("fresh got %0b want %0b", got.fresh, want.fresh));
            if (got.buttons !== want.buttons)
                report($sformatf("common_buttons got %h want %h", got.buttons, want.buttons));
            for (int ax = 0; ax < 4; ax++) begin
                if (got.sticks[ax] !== want.sticks[ax])
                    report($sformatf("stick_%0d got %0d want %0d", ax,
                                     $signed(got.sticks[ax]), $signed(want.sticks[ax])));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_idx = '0;
    logic [CfgW-1:0]        i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_received = 1'b0;
    logic [BtnW-1:0]        i_raw_buttons = '0;
    logic [AxisW-1:0]       i_raw_axis_0 = '0;
    logic [AxisW-1:0]       i_raw_axis_1 = '0;
    logic [AxisW-1:0]       i_raw_axis_2 = '0;
    logic [AxisW-1:0]       i_raw_axis_3 = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_fresh;
    logic [BtnW-1:0]        o_common_buttons;
    logic signed [AxisW-1:0] o_stick_0;
    logic signed [AxisW-1:0] o_stick_1;
    logic signed [AxisW-1:0] o_stick_2;
    logic signed [AxisW-1:0] o_stick_3;

    poll_scoreboard sb = new;
    int  polls_taken = 0;
    bit  quiet = 1'b0;

    gamepad_button_remap_and_stick_condition_unit uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side backpressure, off during quiet stretches
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 13);
    end

    // Accepted requests and results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_poll(i_received, i_raw_buttons,
                             {i_raw_axis_3, i_raw_axis_2, i_raw_axis_1, i_raw_axis_0});
                polls_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result({o_fresh, o_common_buttons,
                                 o_stick_3, o_stick_2, o_stick_1, o_stick_0});
            end
        end
    end

    initial begin
        #2_400_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Drive one request at the falling edge and hold it until taken
    task send_poll(input logic received, input logic [BtnW-1:0] buttons,
                   input logic [3:0][AxisW-1:0] axes);
        int target;
        while (!quiet && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_received    <= received;
        i_raw_buttons <= buttons;
        i_raw_axis_0  <= axes[0];
        i_raw_axis_1  <= axes[1];
        i_raw_axis_2  <= axes[2];
        i_raw_axis_3  <= axes[3];
        target = polls_taken + 1;
        do @(negedge i_clk); while (polls_taken < target);
    endtask

    // Stop sending and wait for every outstanding result
    task settle();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // One write strobe, then the write enable low again before the next write
    task write_register(input t_cfg_idx idx, input logic [CfgW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, value);
        @(negedge i_clk);
    endtask

    function automatic logic [CfgW-1:0] identity_map(int k);
        logic [CfgW-1:0] w;
        w = '0;
        for (int j = 0; j < 4; j++) w[j * 16 + 4 * k + j] = 1'b1;
        return w;
    endfunction

    // Mostly in range, some near the deadzone, some out of range
    function automatic logic [AxisW-1:0] random_axis();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return AxisW'($urandom_range(4, 120));
        if (pick < 8) return AxisW'($urandom_range(58, 66));
        if (pick == 8) return $urandom_range(1) ? AxisW'($urandom_range(0, 3))
                                                : AxisW'($urandom_range(121, 255));
        return AxisW'($urandom_range(0, 255));
    endfunction

    task random_poll();
        logic [BtnW-1:0] b;
        b = BtnW'($urandom_range(0, 65535));
        case ($urandom_range(3))
            0: b |= SelectMask;
            1: b |= StartMask;
            2: b |= SelectMask | StartMask;
            default: ;
        endcase
        send_poll($urandom_range(9) != 0, b,
                  {random_axis(), random_axis(), random_axis(), random_axis()});
    endtask

    task run_phase(input int polls, input logic gen, input logic [CfgW-1:0] m0,
                   input logic [CfgW-1:0] m1, input logic [CfgW-1:0] m2,
                   input logic [CfgW-1:0] m3, input bit hold_mid);
        settle();
        write_register(CFG_GENERALIZE, CfgW'(gen));
        write_register(CFG_MAP_0_3, m0);
        write_register(CFG_MAP_4_7, m1);
        write_register(CFG_MAP_8_11, m2);
        write_register(CFG_MAP_12_15, m3);
        for (int i = 0; i < polls; i++) begin
            if (hold_mid && i == polls / 2) settle();
            random_poll();
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: failed poll before any success, combos, stick edges
        send_poll(1'b0, 16'hFFFF, {8'd255, 8'd0, 8'd120, 8'd4});
        send_poll(1'b1, 16'h000F, {4{8'd62}});
        send_poll(1'b1, 16'h0170, {8'd121, 8'd3, 8'd120, 8'd4});
        send_poll(1'b1, 16'hFFFF, {8'd64, 8'd60, 8'd65, 8'd59});
        send_poll(1'b1, 16'h0000, {8'd30, 8'd94, 8'd255, 8'd0});
        send_poll(1'b1, 16'h017F, {8'd63, 8'd61, 8'd31, 8'd93});
        send_poll(1'b0, 16'h1234, {4{8'd62}});
        send_poll(1'b1, 16'h000E, {8'd0, 8'd255, 8'd3, 8'd121});

        // Raw pass-through
        settle();
        write_register(CFG_GENERALIZE, '0);
        send_poll(1'b1, 16'hFFFF, {4{8'd200}});
        send_poll(1'b1, 16'h8001, {4{8'd62}});
        send_poll(1'b0, 16'h0000, {4{8'd4}});
        send_poll(1'b1, 16'h0000, {4{8'd120}});

        // Identity table: combos against the leftover bits, reserved bits
        settle();
        write_register(CFG_GENERALIZE, CfgW'(1));
        write_register(CFG_MAP_0_3, identity_map(0));
        write_register(CFG_MAP_4_7, identity_map(1));
        write_register(CFG_MAP_8_11, identity_map(2));
        write_register(CFG_MAP_12_15, identity_map(3));
        send_poll(1'b1, 16'h016F, {8'd0, 8'd0, 8'd0, 8'd0});
        send_poll(1'b1, 16'h017F, {8'd100, 8'd20, 8'd62, 8'd70});
        send_poll(1'b1, 16'hFFFF, {8'd255, 8'd255, 8'd255, 8'd255});
        send_poll(1'b1, 16'h0006, {8'd61, 8'd60, 8'd59, 8'd58});
        send_poll(1'b1, 16'hFE80, {8'd66, 8'd65, 8'd64, 8'd63});

        // Random phases over several settings, extremes among them
        run_phase(120, 1'b1, identity_map(0), identity_map(1), identity_map(2),
                  identity_map(3), 1'b0);
        quiet = 1'b1;
        run_phase(120, 1'b1, '1, '1, '1, '1, 1'b0);
        quiet = 1'b0;
        run_phase(100, 1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        run_phase(150, 1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        run_phase(100, 1'b1, '0, '0, '0, '0, 1'b0);
        run_phase(160, 1'b1, {$urandom & $urandom, $urandom & $urandom},
                  {$urandom & $urandom, $urandom & $urandom},
                  {$urandom & $urandom, $urandom & $urandom},
                  {$urandom & $urandom, $urandom & $urandom}, 1'b0);

        settle();
        repeat (4) @(negedge i_clk);
        if (sb.due_results.size() != 0) sb.report("results never arrived");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
